@@ hdl/dtq_pkg.sv @@
// Shared types and constants for the deadline timer queue.
package dtq_pkg;
  localparam int QueueDepth = 16;
  localparam int MaxResults = 16;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int IdxW = $clog2(QueueDepth);
  localparam int FifoDepth = 2;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_ADDED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic {
    K_ADD  = 1'b0,
    K_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [31:0] wake;
  } cmd_t;
endpackage

@@ hdl/dtq_if.sv @@
// Valid/ready channel interfaces for the deadline timer queue.
interface dtq_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  task_id;
  logic [23:0] delay;
  logic [31:0] now;
  modport source (output valid, kind, task_id, delay, now, input ready);
  modport sink (input valid, kind, task_id, delay, now, output ready);
endinterface

interface dtq_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  task_id_res;
  logic [31:0] wake_time;
  logic        last;
  modport source (output valid, status, task_id_res, wake_time, last, input ready);
  modport sink (input valid, status, task_id_res, wake_time, last, output ready);
endinterface

@@ hdl/deadline_timer_queue.sv @@
// Top level of the deadline timer queue.
// channel | dir | payload
// in_ch   | in  | kind, task_id, delay, now
// out_ch  | out | status, task_id_res, wake_time, last
// An add passes through the command queue and then the back end, giving one word.
// A tick passes through the command queue and starts the release pass, which then gives
// one word per cycle while the output is not stalled: one per released task, or one nothing-ready word.
// A stalled output word holds the back end; the two-entry command queue absorbs input.
// Synchronous reset empties the queue and zeroes the current time.
module deadline_timer_queue (
  input logic clk,
  input logic rst,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);
  import dtq_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  dtq_front u_front (.clk, .rst, .in_ch, .cmd, .cmd_valid, .cmd_ready);
  dtq_back  u_back (.clk, .rst, .cmd, .cmd_valid, .cmd_ready, .out_ch);
endmodule

@@ hdl/dtq_front.sv @@
// Front end: tracks current time, computes wake times, queues commands.
module dtq_front (
  input  logic          clk,
  input  logic          rst,
  dtq_in_if.sink        in_ch,
  output dtq_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import dtq_pkg::*;

  logic [31:0] current_time;
  logic [32:0] sum;
  cmd_t        fifo [FifoDepth];
  logic [$clog2(FifoDepth)-1:0] wp, rp;
  logic [$clog2(FifoDepth):0]   cnt;
  cmd_t        incmd;
  logic        push, pop;

  assign sum = {1'b0, current_time} + {9'd0, in_ch.delay};
  always_comb begin
    incmd.kind    = in_ch.kind;
    incmd.task_id = in_ch.task_id;
    if (in_ch.kind == K_TICK) incmd.wake = in_ch.now;
    else incmd.wake = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  end

  assign in_ch.ready = (cnt != ($clog2(FifoDepth)+1)'(FifoDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign pop = cmd_valid && cmd_ready;
  assign cmd_valid = (cnt != '0);
  assign cmd = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= incmd;
    if (rst) begin
      current_time <= '0;
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && in_ch.kind == K_TICK) current_time <= in_ch.now;
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule

@@ hdl/dtq_back.sv @@
// Back end: sorted shift-register queue with insert and release.
module dtq_back (
  input  logic          clk,
  input  logic          rst,
  input  dtq_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  dtq_out_if.source     out_ch
);
  import dtq_pkg::*;

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_REL = 2'b10} state_t;

  state_t      state;
  logic [31:0] wt [QueueDepth];
  logic [7:0]  tk [QueueDepth];
  logic [CntW-1:0] count;
  logic [31:0] tick_now;
  logic [$clog2(MaxResults+1)-1:0] taken;
  logic [QueueDepth-1:0] le;
  logic        head_ok, nxt_ok, out_free;

  always_comb begin
    for (int i = 0; i < QueueDepth; i++)
      le[i] = (CntW'(i) < count) && (wt[i] <= cmd.wake);
  end

  assign out_free = !out_ch.valid || out_ch.ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign head_ok = (count != '0) && (wt[0] <= tick_now);
  assign nxt_ok = (count > CntW'(1)) && (wt[1] <= tick_now) &&
                  (taken + 1'b1 < ($clog2(MaxResults+1))'(MaxResults));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          if (cmd.kind == K_ADD) begin
            out_ch.valid <= 1'b1;
            out_ch.task_id_res <= cmd.task_id;
            out_ch.wake_time <= cmd.wake;
            out_ch.last <= 1'b1;
            if (count == CntW'(QueueDepth)) out_ch.status <= ST_FULL;
            else begin
              out_ch.status <= ST_ADDED;
              for (int i = 0; i < QueueDepth; i++) begin
                if (!le[i]) begin
                  if (i == 0 || le[i-1 < 0 ? 0 : i-1]) begin
                    wt[i] <= cmd.wake;
                    tk[i] <= cmd.task_id;
                  end else begin
                    wt[i] <= wt[i-1 < 0 ? 0 : i-1];
                    tk[i] <= tk[i-1 < 0 ? 0 : i-1];
                  end
                end
              end
              count <= count + 1'b1;
            end
          end else begin
            tick_now <= cmd.wake;
            taken <= '0;
            state <= S_REL;
          end
        end
        S_REL: if (out_free) begin
          out_ch.valid <= 1'b1;
          if (!head_ok) begin
            out_ch.status <= ST_NONE;
            out_ch.task_id_res <= '0;
            out_ch.wake_time <= '0;
            out_ch.last <= 1'b1;
            state <= S_IDLE;
          end else begin
            out_ch.status <= ST_RELEASED;
            out_ch.task_id_res <= tk[0];
            out_ch.wake_time <= wt[0];
            out_ch.last <= !nxt_ok;
            for (int i = 0; i < QueueDepth - 1; i++) begin
              wt[i] <= wt[i+1];
              tk[i] <= tk[i+1];
            end
            count <= count - 1'b1;
            taken <= taken + 1'b1;
            if (!nxt_ok) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/dtq_checker.sv @@
// Port-level checks for the deadline timer queue.
module dtq_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic out_last
);
  import dtq_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_add_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_ADDED || out_status == ST_FULL) |-> out_last)
    else $error("add without last");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_NONE |-> out_last) else $error("none without last");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule

bind deadline_timer_queue dtq_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_last(out_ch.last));

@@ dv/deadline_timer_queue_tb.sv @@
// Testbench for the deadline timer queue: directed and random adds and ticks against a scoreboard.
module deadline_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtq_pkg::*;

  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  task_id;
    logic [31:0] wake;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dtq_in_if  in_ch (clk);
  dtq_out_if out_ch (clk);

  deadline_timer_queue i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] q_wake[$];
  logic [7:0]  q_task[$];
  logic [31:0] cur_time;
  result_t     pending[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  task automatic predict_word(input kind_t kind, input logic [7:0] id,
                              input logic [23:0] delay, input logic [31:0] now);
    logic [32:0] sum;
    logic [31:0] wake;
    int pos;
    int taken;
    if (kind == K_ADD) begin
      sum = {1'b0, cur_time} + {9'd0, delay};
      wake = sum[32] ? TimeMax : sum[31:0];
      if (q_wake.size() >= QueueDepth) begin
        pending.push_back('{ST_FULL, id, wake, 1'b1});
      end else begin
        pos = 0;
        while (pos < q_wake.size() && q_wake[pos] <= wake) pos++;
        q_wake.insert(pos, wake);
        q_task.insert(pos, id);
        pending.push_back('{ST_ADDED, id, wake, 1'b1});
      end
    end else begin
      cur_time = now;
      taken = 0;
      while (taken < q_wake.size() && taken < MaxResults && q_wake[taken] <= cur_time)
        taken++;
      if (taken == 0) begin
        pending.push_back('{ST_NONE, 8'd0, 32'd0, 1'b1});
      end else begin
        for (int i = 0; i < taken; i++) begin
          pending.push_back('{ST_RELEASED, q_task[0], q_wake[0], i == taken - 1});
          void'(q_wake.pop_front());
          void'(q_task.pop_front());
        end
      end
    end
  endtask

  task automatic send_word(input kind_t kind, input logic [7:0] id,
                           input logic [23:0] delay, input logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.task_id <= id;
    in_ch.delay <= delay;
    in_ch.now <= now;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(kind, id, delay, now);
    @(negedge clk);
  endtask

  task automatic add_task(input logic [7:0] id, input logic [23:0] delay);
    send_word(K_ADD, id, delay, $urandom);
  endtask

  task automatic tick(input logic [31:0] now);
    send_word(K_TICK, 8'($urandom), 24'($urandom), now);
  endtask

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.task_id_res, out_ch.wake_time, out_ch.last};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %p", got);
      end else begin
        exp = pending.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", exp, got);
        end
      end
    end
  end

  task automatic drain();
    while (pending.size() != 0) @(negedge clk);
  endtask

  task automatic test_basic();
    tick(32'd0);
    add_task(8'h00, 24'd0);
    add_task(8'hFF, 24'hFFFFFF);
    add_task(8'h55, 24'd10);
    add_task(8'hAA, 24'd10);
    add_task(8'h11, 24'd5);
    tick(32'd4);
    tick(32'd10);
    tick(32'hFFFF_FFFF);
    tick(32'hFFFF_FF00);
    add_task(8'h22, 24'hFFFFFF);
    add_task(8'h33, 24'd0);
    tick(32'd100);
    tick(32'hFFFF_FFFF);
    tick(32'd0);
  endtask

  task automatic test_full();
    for (int i = 0; i < QueueDepth + 3; i++) add_task(8'(i), 24'd7);
    tick(32'd7);
    tick(32'd7);
  endtask

  task automatic test_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        add_task(8'($urandom),
                 ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40)));
      end else if (r < 95) begin
        tick(cur_time + $urandom_range(30));
      end else begin
        tick($urandom);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = K_ADD;
    in_ch.task_id = '0;
    in_ch.delay = '0;
    in_ch.now = '0;
    cur_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 7;
    recv_stall = 47;
    test_basic();
    test_full();
    test_random(140);
    send_idle = 47;
    recv_stall = 7;
    test_random(140);
    send_idle = 0;
    recv_stall = 0;
    test_random(140);
    tick(32'hFFFF_FFFF);
    tick(32'hFFFF_FFFF);
    in_ch.valid <= 1'b0;
    drain();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("deadline_timer_queue_tb passed");
    end else begin
      $display("deadline_timer_queue_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("deadline_timer_queue_tb failed");
    $finish;
  end
endmodule
